@@ rtl/cgfr_pkg.sv @@
`default_nettype none

package cgfr_pkg;

  localparam int unsigned CRC_W = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  localparam int unsigned DATA_WORDS = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] FRAME_DATA_BYTES = 6'd40;
  localparam logic [POS_W-1:0] FRAME_LAST_BYTE = 6'd43;

  localparam logic [WORD_W-1:0] WEIGHT_LOW_RESET = 32'h3A83_126F;
  localparam logic [WORD_W-1:0] WEIGHT_HIGH_RESET = 32'h3F00_0000;

  // configuration register indexes
  localparam logic REG_WEIGHT_LOW = 1'b0;
  localparam logic REG_WEIGHT_HIGH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_APPLIED = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_CRC_MISMATCH = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ rtl/cgfr_crc_byte.sv @@
`default_nettype none

// reflected crc-32 update by one byte, unrolled over the eight bit steps
module cgfr_crc_byte
  import cgfr_pkg::*;
(
  input  wire logic [CRC_W-1:0] crc_in,
  input  wire logic [7:0]       data_in,
  output logic      [CRC_W-1:0] crc_out
);

  always_comb begin
    logic [CRC_W-1:0] r;
    r = crc_in ^ {{(CRC_W-8){1'b0}}, data_in};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    crc_out = r;
  end

endmodule

`default_nettype wire

@@ rtl/crc_checked_gain_frame_receiver.sv @@
// result: appears on m_axis in the cycle after the transfer of the 44th frame byte
// throughput: one byte per cycle while s_axis_tready is high; the crc unit updates one whole byte per clock
// s_axis_tready drops only when the last byte of a frame meets a result still waiting
// reset (rst, synchronous): frame position and crc go to zero, the output is emptied,
// and the weight limits return to 0.001 and 0.5; the word store keeps no reset value
`default_nettype none

module crc_checked_gain_frame_receiver
  import cgfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,

  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data,

  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  input  wire logic [1:0]   s_axis_tuser,   // disarmed, restart

  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [319:0]      m_axis_tdata,   // roll_p/i/d, pitch_p/i/d, yaw_p/i/d gains, filter_weight
  output logic [2:0]        m_axis_tuser    // status (2 bits), weight_applied
);

  logic [WORD_W-1:0] weight_low;
  logic [WORD_W-1:0] weight_high;

  logic [POS_W-1:0]  byte_position;
  logic [CRC_W-1:0]  crc_register;
  logic [CRC_W-1:0]  crc_next;
  logic [WORD_W-1:0] word_store [DATA_WORDS];
  logic [23:0]       received_crc;

  logic              in_fire;
  logic              disarmed;
  logic              restart;
  logic              is_data;
  logic              is_last;
  logic              last_fire;
  logic [3:0]        word_sel;
  logic [CRC_W-1:0]  crc_rx;
  logic [WORD_W*DATA_WORDS-1:0] words_flat;
  status_t           status_next;
  logic              weight_ok;

  assign disarmed = s_axis_tuser[0];
  assign restart  = s_axis_tuser[1];

  assign is_last = (byte_position == FRAME_LAST_BYTE);
  assign is_data = (byte_position < FRAME_DATA_BYTES);
  assign s_axis_tready = !is_last || !m_axis_tvalid || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign last_fire = in_fire && !restart && is_last;
  assign word_sel = byte_position[5:2];

  cgfr_crc_byte u_crc (
    .crc_in  (crc_register),
    .data_in (s_axis_tdata),
    .crc_out (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_low  <= WEIGHT_LOW_RESET;
      weight_high <= WEIGHT_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT_LOW:  weight_low  <= cfg_data;
        REG_WEIGHT_HIGH: weight_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_register  <= '0;
    end else if (in_fire) begin
      if (restart || is_last) begin
        byte_position <= '0;
        crc_register  <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
        if (is_data) begin
          crc_register <= crc_next;
        end
      end
    end
  end

  // little-endian word assembly
  always_ff @(posedge clk) begin
    if (in_fire && !restart && is_data) begin
      unique case (byte_position[1:0])
        2'd0: word_store[word_sel][7:0]   <= s_axis_tdata;
        2'd1: word_store[word_sel][15:8]  <= s_axis_tdata;
        2'd2: word_store[word_sel][23:16] <= s_axis_tdata;
        2'd3: word_store[word_sel][31:24] <= s_axis_tdata;
        default: ;
      endcase
    end
  end

  // the top crc byte is taken straight from the input on the last transfer
  always_ff @(posedge clk) begin
    if (in_fire && !restart && !is_data && !is_last) begin
      unique case (byte_position[1:0])
        2'd0: received_crc[7:0]   <= s_axis_tdata;
        2'd1: received_crc[15:8]  <= s_axis_tdata;
        2'd2: received_crc[23:16] <= s_axis_tdata;
        default: ;
      endcase
    end
  end

  assign crc_rx = {s_axis_tdata, received_crc};

  always_comb begin
    for (int j = 0; j < DATA_WORDS; j++) begin
      words_flat[j*WORD_W +: WORD_W] = word_store[j];
    end
  end

  always_comb begin
    priority if (!disarmed) begin
      status_next = STATUS_IGNORED;
    end else if (~crc_register != crc_rx) begin
      status_next = STATUS_CRC_MISMATCH;
    end else begin
      status_next = STATUS_APPLIED;
    end
  end

  assign weight_ok = (word_store[DATA_WORDS-1] >= weight_low) &&
                     (word_store[DATA_WORDS-1] <= weight_high);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (last_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      if (status_next == STATUS_APPLIED) begin
        m_axis_tdata <= words_flat;
        m_axis_tuser <= {weight_ok, status_next};
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= {1'b0, status_next};
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= FRAME_LAST_BYTE)
    else $error("frame position past last byte");

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_APPLIED) |-> m_axis_tdata == '0)
    else $error("rejected frame carries data");

  a_weight_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STATUS_APPLIED)
    else $error("weight flag on a frame that was not applied");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(last_fire))
    else $error("result without a last byte transfer");

endmodule

`default_nettype wire

@@ tb/crc_checked_gain_frame_receiver_tb.sv @@
`timescale 1ns / 100ps

module crc_checked_gain_frame_receiver_tb;
  import cgfr_pkg::*;

  typedef struct packed {
    logic       restart;
    logic       disarmed;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    status_t          status;
    logic [9:0][31:0] words;
    logic             weight_ok;
  } gain_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_WEIGHT_LOW;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // rx_byte
  logic [1:0]   s_axis_tuser = '0;   // disarmed, restart
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;        // words 0..9: roll, pitch, yaw p/i/d gains, filter_weight
  logic [2:0]   m_axis_tuser;        // status (2 bits), weight_applied

  crc_checked_gain_frame_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  string gain_name [10] = '{"roll_p_gain", "roll_i_gain", "roll_d_gain",
                            "pitch_p_gain", "pitch_i_gain", "pitch_d_gain",
                            "yaw_p_gain", "yaw_i_gain", "yaw_d_gain", "filter_weight"};

  rx_item_t     byte_backlog [$];
  gain_result_t pending_results [$];

  // receiver copy of the block state
  logic [31:0]      weight_lo = WEIGHT_LOW_RESET;
  logic [31:0]      weight_hi = WEIGHT_HIGH_RESET;
  logic [5:0]       frame_pos = '0;
  logic [31:0]      crc_acc = '0;
  logic [9:0][31:0] frame_words = '0;
  logic [31:0]      frame_crc = '0;

  bit failed = 1'b0;
  bit calm = 1'b0;
  bit s_fired = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;
  int queued_items = 0;
  int queued_results = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] crc32_byte(logic [31:0] r, logic [7:0] b);
    r ^= {24'd0, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic take_frame_byte(input rx_item_t it);
    gain_result_t res;
    int sh;
    sh = frame_pos[1:0] * 8;
    if (it.restart) begin
      frame_pos = '0;
      crc_acc = '0;
      frame_crc = '0;
    end else if (frame_pos < FRAME_DATA_BYTES) begin
      crc_acc = crc32_byte(crc_acc, it.rx_byte);
      frame_words[frame_pos[5:2]][sh +: 8] = it.rx_byte;
      frame_pos = frame_pos + 1'b1;
    end else begin
      frame_crc[sh +: 8] = it.rx_byte;
      if (frame_pos < FRAME_LAST_BYTE) begin
        frame_pos = frame_pos + 1'b1;
      end else begin
        res = '0;
        if (!it.disarmed) begin
          res.status = STATUS_IGNORED;
        end else if (~crc_acc != frame_crc) begin
          res.status = STATUS_CRC_MISMATCH;
        end else begin
          res.status = STATUS_APPLIED;
          res.words = frame_words;
          res.weight_ok = frame_words[9] >= weight_lo && frame_words[9] <= weight_hi;
        end
        pending_results.push_back(res);
        frame_pos = '0;
        crc_acc = '0;
        frame_crc = '0;
      end
    end
  endtask

  // stimulus side
  always @(negedge clk) begin : feed
    rx_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_fired) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else if (byte_backlog.size() != 0) begin
        it = byte_backlog.pop_front();
        s_axis_tdata <= it.rx_byte;
        s_axis_tuser <= {it.restart, it.disarmed};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    gain_result_t want;
    if (rst) begin
      s_fired <= 1'b0;
    end else begin
      s_fired <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        take_frame_byte(rx_item_t'({s_axis_tuser[1], s_axis_tuser[0], s_axis_tdata}));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result expected");
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser[1:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
            failed = 1'b1;
          end
          for (int i = 0; i < 10; i++) begin
            if (m_axis_tdata[i*32 +: 32] != want.words[i]) begin
              $error("%s: expected %h, got %h", gain_name[i], want.words[i],
                     m_axis_tdata[i*32 +: 32]);
              failed = 1'b1;
            end
          end
          if (m_axis_tuser[2] != want.weight_ok) begin
            $error("weight_applied: expected %0d, got %0d", want.weight_ok, m_axis_tuser[2]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic dis, input logic rs);
    rx_item_t it;
    it.rx_byte = b;
    it.disarmed = dis;
    it.restart = rs;
    byte_backlog.push_back(it);
    queued_items++;
  endtask

  // full frame; armed only matters on the last byte, crc_flip corrupts the trailer
  task automatic queue_frame(input logic [9:0][31:0] w, input bit armed,
                             input logic [31:0] crc_flip);
    logic [31:0] c;
    logic [7:0] b;
    c = '0;
    for (int i = 0; i < 40; i++) begin
      b = w[i/4][(i%4)*8 +: 8];
      c = crc32_byte(c, b);
      push_item(b, $urandom_range(0, 1), 1'b0);
    end
    c = ~c ^ crc_flip;
    for (int i = 0; i < 3; i++)
      push_item(c[i*8 +: 8], $urandom_range(0, 1), 1'b0);
    push_item(c[31:24], !armed, 1'b0);
    queued_results++;
  endtask

  // partial frame of cut bytes, then a line error
  task automatic queue_broken(input int cut);
    for (int i = 0; i < cut; i++)
      push_item($urandom_range(0, 255), $urandom_range(0, 1), 1'b0);
    push_item($urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return weight_lo;
      1: return weight_hi;
      2: return weight_lo - 1;
      3: return weight_hi + 1;
      4: return $urandom_range(32'h3A00_0000, 32'h3F80_0000);
      5: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0][31:0] pick_frame(logic [31:0] wt);
    logic [9:0][31:0] w;
    for (int i = 0; i < 9; i++)
      w[i] = pick_word();
    w[9] = wt;
    return w;
  endfunction

  task automatic queue_random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      queue_frame(pick_frame(pick_weight()), 1'b0, '0);
    else if (r < 72)
      queue_frame(pick_frame(pick_weight()), 1'b1, $urandom_range(0, 1) ? $urandom : 32'h0);
    else if (r < 84)
      queue_frame(pick_frame(pick_weight()), 1'b0, 32'h1 << $urandom_range(0, 31) | $urandom);
    else
      queue_broken($urandom_range(0, 43));
  endtask

  task automatic set_weight_limits(input logic [31:0] lo, input logic [31:0] hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WEIGHT_LOW;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= REG_WEIGHT_HIGH;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    weight_lo = lo;
    weight_hi = hi;
  endtask

  task automatic wait_until_drained();
    do begin
      @(posedge clk);
      #1;
    end while (byte_backlog.size() != 0 || (s_axis_tvalid && !s_fired) ||
               pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int items_mark;
    int results_mark;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: set_weight_limits(32'h0000_0000, 32'hFFFF_FFFF);
        2: set_weight_limits(32'hFFFF_FFFF, 32'h0000_0000);
        3: begin
          a = $urandom;
          b = $urandom;
          if (a > b) set_weight_limits(b, a);
          else set_weight_limits(a, b);
        end
        4: begin
          a = $urandom_range(32'h3A00_0000, 32'h3F80_0000);
          set_weight_limits(a, a);
          calm = 1'b1;
        end
        default: ;
      endcase

      if (phase == 0) begin
        queue_frame('0, 1'b0, '0);
        queue_frame('1, 1'b0, '0);
        queue_frame(pick_frame(weight_lo), 1'b1, '0);
        queue_frame(pick_frame(weight_hi), 1'b0, 32'h0000_0001);
        queue_broken(43);
        queue_frame(pick_frame(weight_lo), 1'b0, '0);
        queue_broken(0);
        queue_broken(20);
        queue_frame(pick_frame(weight_hi), 1'b0, '0);
        queue_frame(pick_frame(weight_hi + 1), 1'b0, '0);
      end

      items_mark = queued_items;
      results_mark = queued_results;
      while (queued_items - items_mark < 160 || queued_results - results_mark < 3)
        queue_random_frame();
      wait_until_drained();
    end

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
